/* rtl/core/assert_macros.svh */
// assertion macros for the rtl file that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check held at every clock edge outside reset
`define GPRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gamepad report decoder check failed");

// check held at every clock edge, reset included
`define GPRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("gamepad report decoder check failed");

`endif

/* rtl/core/gprd_pkg.sv */
// shared constants and types of the gamepad report decoder
`default_nettype none

package gprd_pkg;

  // report framing
  localparam int REPORT_MAX_BYTES_DEF = 512;
  localparam int HEAD_DEPTH           = 14;
  localparam int ENTRY_BYTES          = HEAD_DEPTH - 1;
  localparam int DIRECT_LEN           = 20;
  localparam int FALLBACK_MIN_LEN     = 9;
  localparam logic [7:0] DIRECT_TAG   = 8'd20;

  // device kinds
  localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
  localparam logic [1:0] KIND_DIRECT     = 2'd1;
  localparam logic [1:0] KIND_COLLECTION = 2'd2;

  // ring capacity limits
  localparam logic [18:0] CAP_MIN   = 19'd1024;
  localparam logic [18:0] CAP_MAX   = 19'd262144;
  localparam logic [18:0] CAP_RESET = CAP_MIN;

  // configuration port
  localparam int PADDR_W = 3;
  localparam logic REG_DEVICE_KIND   = 1'b0;
  localparam logic REG_RING_CAPACITY = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_NONE     = 2'd0,
    CLS_DIRECT   = 2'd1,
    CLS_FALLBACK = 2'd2
  } cls_t;

  // one finished report: its layout and bytes 1 to 13
  typedef struct packed {
    cls_t                         cls;
    logic [ENTRY_BYTES-1:0][7:0]  hb;
  } entry_t;

  typedef struct packed {
    logic           full;
    logic           nonempty;
    logic [QCW-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

/* rtl/core/gprd_if.sv */
// stream interfaces for report bytes in and decoded samples out
`default_nettype none

interface gprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_byte;

  modport source (output valid, report_byte, last_byte, input ready);
  modport sink   (input valid, report_byte, last_byte, output ready);
endinterface

interface gprd_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] left_stick_x;
  logic signed [16:0] left_stick_y;
  logic signed [16:0] right_stick_x;
  logic signed [16:0] right_stick_y;
  logic [15:0]        left_pull;
  logic [15:0]        right_pull;
  logic [15:0]        button_bits;
  logic               sample_valid;
  logic [31:0]        report_number;
  logic [31:0]        parsed_total;
  logic [17:0]        slot_index;

  modport source (output valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
                  left_pull, right_pull, button_bits, sample_valid, report_number,
                  parsed_total, slot_index, input ready);
  modport sink   (input valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
                  left_pull, right_pull, button_bits, sample_valid, report_number,
                  parsed_total, slot_index, output ready);
endinterface

`default_nettype wire

/* rtl/core/gamepad_report_decoder_core.sv */
// gamepad report decoder: top level with configuration registers
// Report bytes enter on in_ch one per request, byte 0 first, last_byte set on
// the final byte. Each report yields one sample request on out_ch: sticks and
// triggers in q1.15, buttons, a parsed flag, the report and parse counts and
// the ring slot. Bytes past REPORT_MAX_BYTES are dropped but still end a report.
// Throughput: one byte per cycle while in_ch.ready is high, including back-to-back reports.
// The finished report is written into the report queue, then popped into the
// output register, where the sample goes valid for the receiver to take.
// The front part counts and classifies bytes; a two-entry report queue sits
// before the conversion stage and its output register, so a stalled receiver
// only holds in_ch once two finished reports wait in the queue.
// Configuration over the APB port: device_kind at byte address 0,
// ring_capacity at byte address 4; pready is always high, reads return the
// register value. Write them only while no report is in flight.
// Synchronous reset clears the byte count, held sample, counters, queue and
// output valid; device_kind returns to unknown and ring_capacity to 1024.
`default_nettype none
`include "assert_macros.svh"

module gamepad_report_decoder_core #(
  parameter int REPORT_MAX_BYTES = gprd_pkg::REPORT_MAX_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  gprd_in_if.sink                      in_ch,
  gprd_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gprd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import gprd_pkg::*;

  logic [1:0]  device_kind;
  logic [18:0] ring_capacity;
  logic        cfg_write;
  logic        q_push;
  logic        q_pop;
  entry_t      q_wr_entry;
  entry_t      q_rd_entry;
  qstat_t      qstat;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind   <= KIND_UNKNOWN;
      ring_capacity <= CAP_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DEVICE_KIND:   device_kind   <= pwdata[1:0];
        REG_RING_CAPACITY: ring_capacity <= pwdata[18:0];
        default:           device_kind   <= device_kind;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_DEVICE_KIND:   prdata = {30'b0, device_kind};
      REG_RING_CAPACITY: prdata = {13'b0, ring_capacity};
      default:           prdata = '0;
    endcase
  end

  gprd_front #(
    .REPORT_MAX_BYTES (REPORT_MAX_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .device_kind (device_kind),
    .qstat       (qstat),
    .push        (q_push),
    .entry       (q_wr_entry)
  );

  gprd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .qstat    (qstat)
  );

  gprd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .entry         (q_rd_entry),
    .qstat         (qstat),
    .pop           (q_pop),
    .ring_capacity (ring_capacity),
    .out_ch        (out_ch)
  );

  // checks
  `GPRD_ASSERT(a_no_push_when_full, !(q_push && qstat.full))
  `GPRD_ASSERT(a_no_pop_when_empty, !(q_pop && !qstat.nonempty))
  `GPRD_ASSERT(a_queue_level, qstat.count <= QCW'(QUEUE_DEPTH))
  `GPRD_ASSERT(a_idle_latency, (q_push && !qstat.nonempty && !out_ch.valid) |=> ##1 out_ch.valid)

endmodule

`default_nettype wire

/* rtl/core/gprd_front.sv */
// front end: byte collection, length count and layout classification
`default_nettype none

module gprd_front #(
  parameter int REPORT_MAX_BYTES = gprd_pkg::REPORT_MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gprd_in_if.sink          in_ch,
  input  logic [1:0]       device_kind,
  input  gprd_pkg::qstat_t qstat,
  output logic             push,
  output gprd_pkg::entry_t entry
);
  import gprd_pkg::*;

  localparam int CW  = $clog2(REPORT_MAX_BYTES + 1);
  localparam int HIW = $clog2(HEAD_DEPTH);

  logic [CW-1:0]               byte_count;
  logic [CW-1:0]               length;
  logic [7:0]                  head [HEAD_DEPTH];
  logic [ENTRY_BYTES-1:0][7:0] view;
  logic                        accept;
  logic                        is_direct;
  logic                        is_fallback;

  // a request is taken whenever the queue has room
  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && in_ch.last_byte;

  // length including this byte, saturating at the maximum
  assign length = (byte_count < CW'(REPORT_MAX_BYTES)) ? byte_count + CW'(1) : byte_count;

  // bytes 1..13 with the current byte merged in
  always_comb begin
    for (int i = 0; i < ENTRY_BYTES; i++) begin
      view[i] = (byte_count == CW'(i + 1)) ? in_ch.report_byte : head[i + 1];
    end
  end

  // layout decision
  assign is_direct   = (device_kind == KIND_DIRECT) && (length == CW'(DIRECT_LEN)) &&
                       (view[0] == DIRECT_TAG);
  assign is_fallback = (length >= CW'(FALLBACK_MIN_LEN)) &&
                       ((device_kind == KIND_DIRECT) || (device_kind == KIND_COLLECTION));

  always_comb begin
    entry.hb = view;
    priority if (is_direct) begin
      entry.cls = CLS_DIRECT;
    end else if (is_fallback) begin
      entry.cls = CLS_FALLBACK;
    end else begin
      entry.cls = CLS_NONE;
    end
  end

  // byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= in_ch.last_byte ? '0 : length;
    end
  end

  // head bytes of the current report
  always_ff @(posedge clk) begin
    if (accept && (byte_count < CW'(HEAD_DEPTH))) begin
      head[byte_count[HIW-1:0]] <= in_ch.report_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gprd_queue.sv */
// two-entry queue of classified reports between front and back
`default_nettype none

module gprd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gprd_pkg::entry_t wr_entry,
  input  logic             pop,
  output gprd_pkg::entry_t rd_entry,
  output gprd_pkg::qstat_t qstat
);
  import gprd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [QCW-1:0]  count;

  assign rd_entry       = slots[rd_ptr];
  assign qstat.count    = count;
  assign qstat.full     = (count == QCW'(QUEUE_DEPTH));
  assign qstat.nonempty = (count != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gprd_back.sv */
// back end: value conversion, held sample, counters and output register
`default_nettype none

module gprd_back (
  input  logic             clk,
  input  logic             rst,
  input  gprd_pkg::entry_t entry,
  input  gprd_pkg::qstat_t qstat,
  output logic             pop,
  input  logic [18:0]      ring_capacity,
  gprd_out_if.source       out_ch
);
  import gprd_pkg::*;

  // signed 16-bit stick to q1.15, positive side scaled by 32768/32767
  function automatic logic signed [16:0] conv_signed(input logic [15:0] raw);
    logic signed [16:0] r;
    if (raw[15]) begin
      r = {1'b1, raw};
    end else begin
      r = {2'b00, raw[14:0]} + {16'b0, raw[14]};
    end
    return r;
  endfunction

  // unsigned 16-bit axis to q1.15, scaled by 65536/65535, centered and optionally negated
  function automatic logic signed [16:0] conv_unsigned(input logic [15:0] raw,
                                                       input logic inv);
    logic [16:0] v;
    v = {1'b0, raw} + {16'b0, raw[15]} - 17'd32768;
    return inv ? -v : v;
  endfunction

  // trigger byte times 32768/255, rounded; x/255 done as (x + x>>8 + 1)>>8
  function automatic logic [15:0] conv_trigger(input logic [7:0] b);
    logic [14:0] x;
    logic [15:0] s;
    logic [7:0]  q;
    x = {b, 7'h7f};
    s = {1'b0, x} + {9'b0, x[14:8]} + 16'd1;
    q = s[15:8];
    return {1'b0, b, 7'b0} + {8'b0, q};
  endfunction

  logic signed [16:0] held_axes [4];
  logic signed [16:0] axes_next [4];
  logic [15:0]        held_trig [2];
  logic [15:0]        trig_next [2];
  logic [15:0]        held_buttons;
  logic [15:0]        buttons_next;
  logic [31:0]        report_counter;
  logic [31:0]        parsed_counter;
  logic [17:0]        slot_pointer;
  logic [18:0]        cap;
  logic [17:0]        slot;
  logic [18:0]        slot_inc;
  logic [17:0]        slot_next;
  logic               ok;

  // take the next report when the output register is free or being drained
  assign pop = qstat.nonempty && (!out_ch.valid || out_ch.ready);
  assign ok  = (entry.cls == CLS_DIRECT) || (entry.cls == CLS_FALLBACK);

  // decoded values, or the held ones when the report did not parse
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      axes_next[k] = held_axes[k];
    end
    trig_next[0] = held_trig[0];
    trig_next[1] = held_trig[1];
    buttons_next = held_buttons;
    unique case (entry.cls)
      CLS_DIRECT: begin
        buttons_next = {entry.hb[2], entry.hb[1]};
        trig_next[0] = conv_trigger(entry.hb[3]);
        trig_next[1] = conv_trigger(entry.hb[4]);
        for (int k = 0; k < 4; k++) begin
          axes_next[k] = conv_signed({entry.hb[6 + 2 * k], entry.hb[5 + 2 * k]});
        end
      end
      CLS_FALLBACK: begin
        buttons_next = '0;
        trig_next[0] = '0;
        trig_next[1] = '0;
        for (int k = 0; k < 4; k++) begin
          axes_next[k] = conv_unsigned({entry.hb[2 * k + 1], entry.hb[2 * k]}, k[0]);
        end
      end
      default: begin
      end
    endcase
  end

  // ring slot with clamped capacity
  always_comb begin
    if (ring_capacity < CAP_MIN) begin
      cap = CAP_MIN;
    end else if (ring_capacity > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = ring_capacity;
    end
    slot      = ({1'b0, slot_pointer} >= cap) ? '0 : slot_pointer;
    slot_inc  = {1'b0, slot} + 19'd1;
    slot_next = (slot_inc >= cap) ? '0 : slot_inc[17:0];
  end

  // held sample and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        held_axes[k] <= '0;
      end
      held_trig[0]   <= '0;
      held_trig[1]   <= '0;
      held_buttons   <= '0;
      report_counter <= '0;
      parsed_counter <= '0;
      slot_pointer   <= '0;
    end else if (pop) begin
      for (int k = 0; k < 4; k++) begin
        held_axes[k] <= axes_next[k];
      end
      held_trig[0]   <= trig_next[0];
      held_trig[1]   <= trig_next[1];
      held_buttons   <= buttons_next;
      report_counter <= report_counter + 32'd1;
      parsed_counter <= parsed_counter + {31'b0, ok};
      slot_pointer   <= slot_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pop) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.left_stick_x  <= axes_next[0];
      out_ch.left_stick_y  <= axes_next[1];
      out_ch.right_stick_x <= axes_next[2];
      out_ch.right_stick_y <= axes_next[3];
      out_ch.left_pull     <= trig_next[0];
      out_ch.right_pull    <= trig_next[1];
      out_ch.button_bits   <= buttons_next;
      out_ch.sample_valid  <= ok;
      out_ch.report_number <= report_counter + 32'd1;
      out_ch.parsed_total  <= parsed_counter + {31'b0, ok};
      out_ch.slot_index    <= slot;
    end
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for gamepad_report_decoder_core: byte streams in, decoded samples out
module testbench;
  import gprd_pkg::*;

  // report limit kept short so an overlong report stays cheap
  localparam int REPORT_MAX     = 40;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_BYTES    = 100;
  localparam int OVERLONG_PHASE = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_SHOWN      = 10;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_DEVICE_KIND   = {REG_DEVICE_KIND, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_RING_CAPACITY = {REG_RING_CAPACITY, 2'b00};

  // register settings walked by the random phases
  localparam logic [1:0] PHASE_KIND [NUM_PHASES] =
    '{KIND_DIRECT, KIND_COLLECTION, KIND_RESERVED, KIND_UNKNOWN, KIND_DIRECT};
  localparam logic [31:0] PHASE_CAP [NUM_PHASES] =
    '{32'd1024, 32'h0007_FFFF, 32'd0, 32'd262144, 32'd1500};

  typedef struct packed {
    logic signed [16:0] left_x;
    logic signed [16:0] left_y;
    logic signed [16:0] right_x;
    logic signed [16:0] right_y;
    logic [15:0]        left_pull;
    logic [15:0]        right_pull;
    logic [15:0]        buttons;
    logic               parsed;
    logic [31:0]        report_no;
    logic [31:0]        parsed_no;
    logic [17:0]        slot;
  } sample_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_op_t;

  typedef struct packed {
    row_op_t             op;
    logic [PADDR_W-1:0]  addr;
    logic [31:0]         data;
    logic [7:0]          rbyte;
    logic                last;
    logic                typed;
    sample_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gprd_in_if  in_ch ();
  gprd_out_if out_ch ();

  gamepad_report_decoder_core #(
    .REPORT_MAX_BYTES (REPORT_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as predicted
  logic [1:0]         kind_m;
  logic [18:0]        cap_m;
  int unsigned        len_m;
  logic [7:0]         head_m [HEAD_DEPTH];
  logic signed [16:0] axes_m [4];
  logic [15:0]        pull_m [2];
  logic [15:0]        btn_m;
  logic [31:0]        rep_m;
  logic [31:0]        par_m;
  int unsigned        slot_m;

  sample_t   pending_samples [$];
  dir_row_t  dir_rows [$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        bytes_sent = 0;
  int        writes_done = 0;
  int        hold_asked = 0;
  int        hold_done = 0;
  int        idle_cycles = 0;

  function automatic void reset_model();
    kind_m = KIND_UNKNOWN;
    cap_m  = CAP_RESET;
    len_m  = 0;
    foreach (head_m[i]) head_m[i] = '0;
    foreach (axes_m[i]) axes_m[i] = '0;
    pull_m[0] = '0;
    pull_m[1] = '0;
    btn_m  = '0;
    rep_m  = '0;
    par_m  = '0;
    slot_m = 0;
  endfunction

  // signed stick word to q1.15, positive side stretched to full scale
  function automatic logic signed [16:0] stick_q15(input logic [15:0] raw);
    int v;
    if (!raw[15]) v = (int'(raw) * 32768 + 16383) / 32767;
    else v = int'(raw) - 65536;
    return v[16:0];
  endfunction

  // unsigned axis word to centered q1.15, optionally inverted
  function automatic logic signed [16:0] axis_q15(input logic [15:0] raw, input bit invert);
    longint scaled;
    int v;
    scaled = (longint'(raw) * 65536 + 32767) / 65535;
    v = int'(scaled) - 32768;
    if (invert) v = -v;
    return v[16:0];
  endfunction

  function automatic logic [15:0] pull_q15(input logic [7:0] b);
    int v;
    v = (int'(b) * 32768 + 127) / 255;
    return v[15:0];
  endfunction

  // advance the predicted state by one accepted byte; returns 1 when a sample is due
  function automatic bit decode_byte(input logic [7:0] b, input logic last, output sample_t s);
    bit ok;
    int unsigned cap_now;
    int unsigned slot;
    s = '0;
    ok = 1'b0;
    if (len_m < REPORT_MAX) begin
      if (len_m < HEAD_DEPTH) head_m[len_m] = b;
      len_m++;
    end
    if (!last) return 1'b0;
    if (kind_m == KIND_DIRECT && len_m == DIRECT_LEN && head_m[1] == DIRECT_TAG) begin
      btn_m = {head_m[3], head_m[2]};
      pull_m[0] = pull_q15(head_m[4]);
      pull_m[1] = pull_q15(head_m[5]);
      for (int k = 0; k < 4; k++) axes_m[k] = stick_q15({head_m[7 + 2*k], head_m[6 + 2*k]});
      ok = 1'b1;
    end else if (len_m >= FALLBACK_MIN_LEN &&
                 (kind_m == KIND_DIRECT || kind_m == KIND_COLLECTION)) begin
      for (int k = 0; k < 4; k++)
        axes_m[k] = axis_q15({head_m[2 + 2*k], head_m[1 + 2*k]}, (k % 2) == 1);
      pull_m[0] = '0;
      pull_m[1] = '0;
      btn_m = '0;
      ok = 1'b1;
    end
    len_m = 0;
    // ring slot with clamped capacity
    cap_now = cap_m;
    if (cap_now < CAP_MIN) cap_now = CAP_MIN;
    if (cap_now > CAP_MAX) cap_now = CAP_MAX;
    if (slot_m >= cap_now) slot_m = 0;
    slot = slot_m;
    slot_m = (slot + 1 >= cap_now) ? 0 : slot + 1;
    rep_m++;
    if (ok) par_m++;
    s.left_x     = axes_m[0];
    s.left_y     = axes_m[1];
    s.right_x    = axes_m[2];
    s.right_y    = axes_m[3];
    s.left_pull  = pull_m[0];
    s.right_pull = pull_m[1];
    s.buttons    = btn_m;
    s.parsed     = ok;
    s.report_no  = rep_m;
    s.parsed_no  = par_m;
    s.slot       = slot[17:0];
    return 1'b1;
  endfunction

  // random byte biased toward the word extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // directed table
  function automatic void row_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    dir_rows.push_back('{op: ROW_WRITE, addr: a, data: d, rbyte: '0, last: 1'b0,
                         typed: 1'b0, want: '0});
  endfunction

  function automatic void row_byte(input logic [7:0] b, input logic last);
    dir_rows.push_back('{op: ROW_BYTE, addr: '0, data: '0, rbyte: b, last: last,
                         typed: 1'b0, want: '0});
  endfunction

  function automatic void row_checked(input logic [7:0] b, input sample_t want);
    dir_rows.push_back('{op: ROW_BYTE, addr: '0, data: '0, rbyte: b, last: 1'b1,
                         typed: 1'b1, want: want});
  endfunction

  function automatic void build_directed();
    // direct layout: full-scale and near-zero sticks, full and empty triggers, all buttons
    logic [7:0] direct_rep [DIRECT_LEN] = '{
      8'h00, 8'h14, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'h80,
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'h3C, 8'hC3, 8'h11, 8'h22, 8'h44, 8'h88};
    // unknown device after reset: nothing parses, all held values zero
    row_checked(8'hFF, '{left_x: 0, left_y: 0, right_x: 0, right_y: 0, left_pull: 0,
                         right_pull: 0, buttons: 0, parsed: 0, report_no: 1,
                         parsed_no: 0, slot: 0});
    row_write(ADDR_DEVICE_KIND, 32'(KIND_DIRECT));
    row_write(ADDR_RING_CAPACITY, 32'(CAP_MIN));
    for (int i = 0; i < DIRECT_LEN - 1; i++) row_byte(direct_rep[i], 1'b0);
    row_checked(direct_rep[DIRECT_LEN-1],
                '{left_x: 32768, left_y: -32768, right_x: 0, right_y: -1, left_pull: 32768,
                  right_pull: 0, buttons: 16'hFFFF, parsed: 1, report_no: 2,
                  parsed_no: 1, slot: 1});
    // short report: held values repeat, not parsed
    row_byte(8'hA5, 1'b0);
    row_byte(8'h14, 1'b0);
    row_checked(8'h5A, '{left_x: 32768, left_y: -32768, right_x: 0, right_y: -1,
                         left_pull: 32768, right_pull: 0, buttons: 16'hFFFF, parsed: 0,
                         report_no: 3, parsed_no: 1, slot: 2});
  endfunction

  // offer one byte, in bursts with random gaps; valid stays high inside a burst
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input sample_t want);
    int gap;
    sample_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.report_byte = b;
    in_ch.last_byte   = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (decode_byte(b, last, pred)) pending_samples.push_back(typed ? want : pred);
  endtask

  // one report; tag < 0 leaves byte 1 random
  task automatic send_report(input int len, input int tag);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (i == 1 && tag >= 0) ? tag[7:0] : pick_byte();
      send_byte(b, i == len - 1, 1'b0, '0);
    end
  endtask

  // stop offering and wait until every sample has come out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_DEVICE_KIND) kind_m = data[1:0];
    else cap_m = data[18:0];
    writes_done++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // receiver: random stall patterns, plus a long hold-off on request
  initial begin : receiver
    int pat_left;
    logic [15:0] pat;
    pat_left = 0;
    pat = '0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (pat_left == 0) begin
          pat_left = 16;
          pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom());
        end
        out_ch.ready = pat[pat_left - 1];
        pat_left--;
      end
    end
  end

  // sample check against the oldest pending expectation
  always @(posedge clk) begin : sample_check
    sample_t got;
    sample_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{left_x: out_ch.left_stick_x, left_y: out_ch.left_stick_y,
              right_x: out_ch.right_stick_x, right_y: out_ch.right_stick_y,
              left_pull: out_ch.left_pull, right_pull: out_ch.right_pull,
              buttons: out_ch.button_bits, parsed: out_ch.sample_valid,
              report_no: out_ch.report_number, parsed_no: out_ch.parsed_total,
              slot: out_ch.slot_index};
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected sample: report %0d slot %0d", got.report_no, got.slot);
      end else begin
        want = pending_samples.pop_front();
        if (got.left_x !== want.left_x || got.left_y !== want.left_y ||
            got.right_x !== want.right_x || got.right_y !== want.right_y ||
            got.left_pull !== want.left_pull || got.right_pull !== want.right_pull ||
            got.buttons !== want.buttons || got.parsed !== want.parsed ||
            got.report_no !== want.report_no || got.parsed_no !== want.parsed_no ||
            got.slot !== want.slot) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $write("report %0d expected: lx=%0d ly=%0d rx=%0d ry=%0d",
                   want.report_no, want.left_x, want.left_y, want.right_x, want.right_y);
            $display(" lp=%0d rp=%0d btn=%h ok=%0b n=%0d p=%0d slot=%0d",
                     want.left_pull, want.right_pull, want.buttons, want.parsed,
                     want.report_no, want.parsed_no, want.slot);
            $write("report %0d actual:   lx=%0d ly=%0d rx=%0d ry=%0d",
                   want.report_no, got.left_x, got.left_y, got.right_x, got.right_y);
            $display(" lp=%0d rp=%0d btn=%h ok=%0b n=%0d p=%0d slot=%0d",
                     got.left_pull, got.right_pull, got.buttons, got.parsed,
                     got.report_no, got.parsed_no, got.slot);
          end
        end
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("gamepad_report_decoder_core: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int phase_bytes;
    int len;
    int tag;
    int shape;
    in_ch.valid = 1'b0;
    in_ch.report_byte = '0;
    in_ch.last_byte = 1'b0;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    build_directed();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_WRITE) begin
        wait_drained();
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_byte(dir_rows[i].rbyte, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_reg(ADDR_DEVICE_KIND, 32'(PHASE_KIND[p]));
      write_reg(ADDR_RING_CAPACITY, PHASE_CAP[p]);
      if (p == 0) hold_asked++;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        shape = $urandom_range(0, 99);
        if (shape < 40) begin
          len = DIRECT_LEN;
          tag = DIRECT_TAG;
        end else if (shape < 65) begin
          len = ($urandom_range(0, 1) == 0) ? $urandom_range(FALLBACK_MIN_LEN, DIRECT_LEN - 1)
                                            : $urandom_range(DIRECT_LEN + 1, 40);
          tag = -1;
        end else if (shape < 75) begin
          // direct length with a wrong tag byte
          len = DIRECT_LEN;
          tag = $urandom_range(0, 255);
          if (tag == DIRECT_TAG) tag = tag + 1;
        end else if (shape < 82) begin
          // right tag, length one off
          len = ($urandom_range(0, 1) == 0) ? DIRECT_LEN - 1 : DIRECT_LEN + 1;
          tag = DIRECT_TAG;
        end else if (shape < 90) begin
          len = FALLBACK_MIN_LEN - $urandom_range(0, 1);
          tag = -1;
        end else begin
          len = $urandom_range(1, FALLBACK_MIN_LEN - 1);
          tag = -1;
        end
        send_report(len, tag);
        phase_bytes += len;
      end
      // overlong report: length saturates, final flag still ends it
      if (p == OVERLONG_PHASE) send_report($urandom_range(REPORT_MAX + 1, REPORT_MAX + 24),
                                           DIRECT_TAG);
    end

    wait_drained();
    if (pending_samples.size() != 0) begin
      $display("%0d expected samples never arrived", pending_samples.size());
      mismatches += pending_samples.size();
    end
    $display("covered %0d bytes in %0d reports (%0d parsed) over %0d register writes",
             bytes_sent, rep_m, par_m, writes_done);
    $display("all device kinds, clamped capacities, overlong and broken reports");
    if (mismatches == 0) begin
      $display("gamepad_report_decoder_core: match");
    end else begin
      $display("gamepad_report_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

/* gamepad_report_decoder_core.f */
+incdir+rtl/core
rtl/core/gprd_pkg.sv
rtl/core/gprd_if.sv
rtl/core/gprd_front.sv
rtl/core/gprd_queue.sv
rtl/core/gprd_back.sv
rtl/core/gamepad_report_decoder_core.sv
verif/testbench.sv
